// ===== rtl/core/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared widths, limits and control types of the row mode finder.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // control from the table sequencer to the leader tracker
    typedef struct packed {
        logic upd;  // a value was counted: compare against the leader
        logic ovf;  // a new value found the table full
        logic clr;  // row result taken: start a new row
    } t_lead_ctl;

endpackage

// ===== rtl/core/rmf_ram.sv =====
// ----------------------------------------------------------------------------
// rmf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Contents are not reset.
// ----------------------------------------------------------------------------
module rmf_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rmf_lead.sv =====
// ----------------------------------------------------------------------------
// rmf_lead
// Leader tracker: holds the current mode value, its count and the row
// overflow flag. A value takes the lead only by exceeding the held count.
// ----------------------------------------------------------------------------
module rmf_lead #(
    parameter int KEY_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rmf_pkg::t_lead_ctl        i_ctl,
    input  logic [KEY_BITS-1:0]       i_key,
    input  logic [rmf_pkg::CNT_W-1:0] i_count,
    output logic [KEY_BITS-1:0]       o_best_value,
    output logic [rmf_pkg::CNT_W-1:0] o_best_count,
    output logic                      o_overflow
);

    logic [KEY_BITS-1:0]       r_best_value;
    logic [rmf_pkg::CNT_W-1:0] r_best_count;
    logic                      r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_best_value <= '0;
            r_best_count <= '0;
            r_overflow   <= 1'b0;
        end else begin
            if (i_ctl.upd && (i_count > r_best_count)) begin
                r_best_value <= i_key;
                r_best_count <= i_count;
            end
            if (i_ctl.ovf) begin
                r_overflow <= 1'b1;
            end
        end
    end

    assign o_best_value = r_best_value;
    assign o_best_count = r_best_count;
    assign o_overflow   = r_overflow;

endmodule

// ===== rtl/core/row_mode_finder_core.sv =====
// ----------------------------------------------------------------------------
// row_mode_finder_core
// Finds the most frequent value of each row. Distinct values and their counts
// sit in one table RAM, searched entry by entry and updated in place.
// ----------------------------------------------------------------------------
// Throughput: an item is taken in S_IDLE, then probes k table entries in S_CMP
//   (1 up to the entries in use in the row); the single table read port sets
//   this, one probe per cycle, and no new item is taken until S_IDLE. A
//   row-final request also passes S_EMIT, held while the previous result waits.
// Result: after the final element's last probe, S_EMIT loads the output
//   register; the next row is accepted while a result waits to be taken.
// Reset: synchronous, clears the row fill and leader; the table RAM is not
//   cleared and needs no sweep, as only entries below the fill can hit.
// ----------------------------------------------------------------------------
module row_mode_finder_core #(
    parameter int ROW_MAX    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rmf_pkg::VAL_W-1:0] i_value,
    input  logic                      i_last_in_row,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rmf_pkg::VAL_W-1:0] o_mode_value,
    output logic [rmf_pkg::CNT_W-1:0] o_mode_count,
    output logic                      o_table_overflow
);

    localparam int KEY_BITS = (VALUE_BITS < rmf_pkg::VAL_W) ? VALUE_BITS : rmf_pkg::VAL_W;
    localparam int IDX_W    = $clog2(ROW_MAX);
    localparam int ENT_W    = $clog2(ROW_MAX + 1);
    localparam int WORD_W   = KEY_BITS + rmf_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [IDX_W-1:0]          r_idx;
    logic [ENT_W-1:0]          r_entries;
    logic [KEY_BITS-1:0]       r_key;
    logic                      r_last;
    logic                      r_out_valid;
    logic [rmf_pkg::VAL_W-1:0] r_mode_value;
    logic [rmf_pkg::CNT_W-1:0] r_mode_count;
    logic                      r_overflow;

    logic                      w_accept;
    logic                      w_emit;
    logic                      w_hit;
    logic                      w_more;
    logic                      w_full;
    logic [ENT_W-1:0]          w_nxt_idx;
    logic [rmf_pkg::CNT_W-1:0] w_old_cnt;
    logic [rmf_pkg::CNT_W-1:0] w_new_cnt;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic                      w_re;
    logic [IDX_W-1:0]          w_raddr;
    logic [WORD_W-1:0]         w_rd_data;
    rmf_pkg::t_lead_ctl        w_lead_ctl;
    logic [KEY_BITS-1:0]       w_best_value;
    logic [rmf_pkg::CNT_W-1:0] w_best_count;
    logic                      w_best_ovf;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // probe of the entry read last cycle
    assign w_old_cnt = w_rd_data[KEY_BITS +: rmf_pkg::CNT_W];
    assign w_hit     = (ENT_W'(r_idx) < r_entries) && (w_rd_data[KEY_BITS-1:0] == r_key);
    assign w_nxt_idx = ENT_W'(r_idx) + ENT_W'(1);
    assign w_more    = w_nxt_idx < r_entries;
    assign w_full    = (r_entries == ENT_W'(ROW_MAX));

    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_new_cnt  = rmf_pkg::CNT_ONE;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_lead_ctl = '0;
        w_lead_ctl.clr = w_emit;
        case (r_state)
            S_IDLE: begin
                w_re = w_accept;
            end
            S_CMP: begin
                if (w_hit) begin
                    w_we      = 1'b1;
                    w_new_cnt = (w_old_cnt == rmf_pkg::CNT_MAX) ? rmf_pkg::CNT_MAX
                                                                : w_old_cnt + rmf_pkg::CNT_ONE;
                    w_lead_ctl.upd = 1'b1;
                end else if (w_more) begin
                    w_re    = 1'b1;
                    w_raddr = w_nxt_idx[IDX_W-1:0];
                end else if (!w_full) begin
                    // append the new value at the end of the table
                    w_we    = 1'b1;
                    w_waddr = r_entries[IDX_W-1:0];
                    w_lead_ctl.upd = 1'b1;
                end else begin
                    w_lead_ctl.ovf = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key   <= i_value[KEY_BITS-1:0];
                        r_last  <= i_last_in_row;
                        r_idx   <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!w_hit && w_more) begin
                        r_idx <= w_nxt_idx[IDX_W-1:0];
                    end else begin
                        if (!w_hit && !w_full) begin
                            r_entries <= r_entries + ENT_W'(1);
                        end
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (w_emit) begin
                        r_entries <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_emit) begin
                r_out_valid  <= 1'b1;
                r_mode_value <= rmf_pkg::VAL_W'(w_best_value);
                r_mode_count <= w_best_count;
                r_overflow   <= w_best_ovf;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    rmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROW_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_new_cnt, r_key}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    rmf_lead #(
        .KEY_BITS (KEY_BITS)
    ) u_lead (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_lead_ctl),
        .i_key        (r_key),
        .i_count      (w_new_cnt),
        .o_best_value (w_best_value),
        .o_best_count (w_best_count),
        .o_overflow   (w_best_ovf)
    );

    assign o_out_valid      = r_out_valid;
    assign o_mode_value     = r_mode_value;
    assign o_mode_count     = r_mode_count;
    assign o_table_overflow = r_overflow;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= ENT_W'(ROW_MAX))
        else $error("table fill beyond depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !o_in_ready)
        else $error("table written while taking requests");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside row end");

    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_entries == '0) && (w_best_count == '0))
        else $error("row state not cleared after result");

endmodule
